[hw/rtl/sdlc_pkg.sv]
// ----------------------------------------------------------------------------
// Speaker distance level compensation package
// Shared constants, register indexes and beat payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package sdlc_pkg;

    // Coordinate width of positions, two's complement.
    localparam int COORD_BITS   = 16;
    // Upper clamp of the level in dB.
    localparam int MAX_LEVEL_DB = 78;
    localparam int LEVEL_BITS   = 15;
    localparam logic [LEVEL_BITS-1:0] MAX_LEVEL = LEVEL_BITS'(MAX_LEVEL_DB * 256);
    localparam logic [LEVEL_BITS-1:0] REF_LEVEL_RESET = 15'd15360;
    // Fraction bits of the log2 result and mantissa width (Q.30 in [1,2)).
    localparam int FRAC_BITS = 16;
    localparam int MANT_BITS = 31;
    // 256 * 10 * log10(2) in Q.16.
    localparam int K_BITS = 26;
    localparam logic [K_BITS-1:0] LOG_K = 26'd50504453;

    // Register map index (byte address / 4).
    typedef enum logic [2:0] {
        REG_SPEAKER_X = 3'd0,
        REG_SPEAKER_Y = 3'd1,
        REG_SPEAKER_Z = 3'd2,
        REG_CENTER_X  = 3'd3,
        REG_CENTER_Y  = 3'd4,
        REG_CENTER_Z  = 3'd5,
        REG_REF_LEVEL = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] listener_x;
        logic signed [COORD_BITS-1:0] listener_y;
        logic signed [COORD_BITS-1:0] listener_z;
    } in_beat_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  clamped;
    } out_beat_t;

endpackage

`default_nettype wire

[hw/rtl/speaker_distance_level_comp_core.sv]
// ----------------------------------------------------------------------------
// Speaker distance level compensation core
// Level for one speaker from the listener position: ref_level plus
// 10*log10(d0/d) on squared distances, clamped to 0 .. 78 dB.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle unless the output register holds a beat
// that is not taken; the 16 squaring stages of the log2 mantissa set the
// depth, each holding one 31x31 multiplier per lane.
// Reset: synchronous active-low aresetn empties the pipeline and sets the
// speaker and center registers to 0 and ref_level to 15360.
`default_nettype none

module speaker_distance_level_comp_core (
    input  wire                        aclk,
    input  wire                        aresetn,
    // Input channel
    input  wire                        s_valid,
    output logic                       s_ready,
    input  sdlc_pkg::in_beat_t         s_data,
    // Result channel
    output logic                       m_valid,
    input  wire                        m_ready,
    output sdlc_pkg::out_beat_t        m_data,
    // Configuration port
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire  [4:0]                 paddr,
    input  wire  [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int CB  = sdlc_pkg::COORD_BITS;
    localparam int VW  = 2 * CB + 2;            // sum of three squares
    localparam int NB  = $clog2(VW);            // top-bit index
    localparam int MB  = sdlc_pkg::MANT_BITS;
    localparam int FB  = sdlc_pkg::FRAC_BITS;
    localparam int NW  = VW + MB;
    localparam int LW  = NB + FB;               // log2 value width
    localparam int PW  = LW + sdlc_pkg::K_BITS; // scaled product width
    localparam int DMW = PW + 1 - 32;           // rounded delta width
    localparam int SW  = DMW + 2;               // signed raw level width
    localparam int NIT = FB;                    // squaring iterations
    localparam int NS  = 4 + NIT + 1 + 2;       // stages before output

    typedef struct packed {
        logic [NB-1:0] n0;
        logic [NB-1:0] n1;
        logic          z0;
        logic          z1;
    } side_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [CB-1:0] spk_reg [3];
    logic signed [CB-1:0] ctr_reg [3];
    logic [sdlc_pkg::LEVEL_BITS-1:0] ref_level_reg;
    logic                 cfg_wr;
    sdlc_pkg::reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = sdlc_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                spk_reg[i] <= '0;
                ctr_reg[i] <= '0;
            end
            ref_level_reg <= sdlc_pkg::REF_LEVEL_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                sdlc_pkg::REG_SPEAKER_X: spk_reg[0] <= pwdata[CB-1:0];
                sdlc_pkg::REG_SPEAKER_Y: spk_reg[1] <= pwdata[CB-1:0];
                sdlc_pkg::REG_SPEAKER_Z: spk_reg[2] <= pwdata[CB-1:0];
                sdlc_pkg::REG_CENTER_X:  ctr_reg[0] <= pwdata[CB-1:0];
                sdlc_pkg::REG_CENTER_Y:  ctr_reg[1] <= pwdata[CB-1:0];
                sdlc_pkg::REG_CENTER_Z:  ctr_reg[2] <= pwdata[CB-1:0];
                sdlc_pkg::REG_REF_LEVEL:
                    ref_level_reg <= pwdata[sdlc_pkg::LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back, zero-extended.
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            sdlc_pkg::REG_SPEAKER_X: prdata = 32'(unsigned'(spk_reg[0]));
            sdlc_pkg::REG_SPEAKER_Y: prdata = 32'(unsigned'(spk_reg[1]));
            sdlc_pkg::REG_SPEAKER_Z: prdata = 32'(unsigned'(spk_reg[2]));
            sdlc_pkg::REG_CENTER_X:  prdata = 32'(unsigned'(ctr_reg[0]));
            sdlc_pkg::REG_CENTER_Y:  prdata = 32'(unsigned'(ctr_reg[1]));
            sdlc_pkg::REG_CENTER_Z:  prdata = 32'(unsigned'(ctr_reg[2]));
            sdlc_pkg::REG_REF_LEVEL: prdata = 32'(ref_level_reg);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages advance together unless the output
    // register holds a beat that is not taken.
    // ------------------------------------------------------------------
    logic          adv;
    logic [NS-1:0] vld_reg;
    logic          m_valid_reg;
    sdlc_pkg::out_beat_t m_data_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[NS-2:0], s_valid};
            m_valid_reg <= vld_reg[NS-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: coordinate differences for both distances.
    // ------------------------------------------------------------------
    logic signed [CB:0] dl_reg [3];
    logic signed [CB:0] dc_reg [3];
    logic signed [CB-1:0] lis [3];

    assign lis[0] = s_data.listener_x;
    assign lis[1] = s_data.listener_y;
    assign lis[2] = s_data.listener_z;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                dl_reg[i] <= {lis[i][CB-1], lis[i]} - {spk_reg[i][CB-1], spk_reg[i]};
                dc_reg[i] <= {spk_reg[i][CB-1], spk_reg[i]} - {ctr_reg[i][CB-1], ctr_reg[i]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares. Stage 3: sums of squares.
    // ------------------------------------------------------------------
    logic [2*CB-1:0] sl_reg [3];
    logic [2*CB-1:0] sc_reg [3];
    logic [2*CB+1:0] pl, pc;
    logic [VW-1:0]   d0_reg, d_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                sl_reg[i] <= (2*CB)'(unsigned'((2*CB+2)'(dl_reg[i])
                                               * (2*CB+2)'(dl_reg[i])));
                sc_reg[i] <= (2*CB)'(unsigned'((2*CB+2)'(dc_reg[i])
                                               * (2*CB+2)'(dc_reg[i])));
            end
            d0_reg <= VW'(sl_reg[0]) + VW'(sl_reg[1]) + VW'(sl_reg[2]);
            d_reg  <= VW'(sc_reg[0]) + VW'(sc_reg[1]) + VW'(sc_reg[2]);
        end
    end

    // Unused product bits of the signed squares are discarded above.
    assign pl = '0;
    assign pc = '0;

    // ------------------------------------------------------------------
    // Stage 4: top set bit and zero detection.
    // ------------------------------------------------------------------
    logic [NB-1:0] n0_c, n1_c;
    logic [VW-1:0] v0_reg, v1_reg;
    side_t         side_reg [NIT+1];
    side_t         side4_reg;

    always_comb begin
        n0_c = '0;
        n1_c = '0;
        for (int i = 0; i < VW; i++) begin
            if (d0_reg[i]) n0_c = NB'(i);
            if (d_reg[i])  n1_c = NB'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            v0_reg       <= d0_reg | VW'(pl);
            v1_reg       <= d_reg | VW'(pc);
            side4_reg.n0 <= n0_c;
            side4_reg.n1 <= n1_c;
            side4_reg.z0 <= (d0_reg == '0);
            side4_reg.z1 <= (d_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: normalize to a Q.30 mantissa, truncating shifted-out bits.
    // ------------------------------------------------------------------
    logic [MB-1:0] m0_reg [NIT+1];
    logic [MB-1:0] m1_reg [NIT+1];
    logic [FB-1:0] f0_reg [NIT+1];
    logic [FB-1:0] f1_reg [NIT+1];
    logic [NW-1:0] norm0, norm1;

    assign norm0 = {v0_reg, {MB{1'b0}}} << (NB'(VW - 1) - side4_reg.n0);
    assign norm1 = {v1_reg, {MB{1'b0}}} << (NB'(VW - 1) - side4_reg.n1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            m0_reg[0]   <= norm0[NW-1 -: MB];
            m1_reg[0]   <= norm1[NW-1 -: MB];
            f0_reg[0]   <= '0;
            f1_reg[0]   <= '0;
            side_reg[0] <= side4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 6..21: one fraction bit per stage by squaring the mantissa.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NIT; k++) begin : g_iter
        logic [2*MB-1:0] p0, p1;
        logic [MB:0]     q0, q1;

        assign p0 = m0_reg[k] * m0_reg[k];
        assign p1 = m1_reg[k] * m1_reg[k];
        assign q0 = p0[2*MB-1:MB-1];
        assign q1 = p1[2*MB-1:MB-1];

        always_ff @(posedge aclk) begin
            if (adv) begin
                m0_reg[k+1]   <= q0[MB] ? q0[MB:1] : q0[MB-1:0];
                m1_reg[k+1]   <= q1[MB] ? q1[MB:1] : q1[MB-1:0];
                f0_reg[k+1]   <= {f0_reg[k][FB-2:0], q0[MB]};
                f1_reg[k+1]   <= {f1_reg[k][FB-2:0], q1[MB]};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 22: log difference, sign and magnitude.
    // Stage 23: scale by 256*10*log10(2).
    // ------------------------------------------------------------------
    logic signed [LW:0] ldiff;
    logic [LW-1:0]      mag_reg;
    logic               neg_reg, negp_reg;
    logic               z0d_reg, z1d_reg, z0p_reg, z1p_reg;
    logic [PW-1:0]      prod_reg;

    assign ldiff = $signed({1'b0, side_reg[NIT].n0, f0_reg[NIT]})
                 - $signed({1'b0, side_reg[NIT].n1, f1_reg[NIT]});

    always_ff @(posedge aclk) begin
        if (adv) begin
            neg_reg  <= ldiff[LW];
            mag_reg  <= ldiff[LW] ? LW'(-ldiff) : LW'(ldiff);
            z0d_reg  <= side_reg[NIT].z0;
            z1d_reg  <= side_reg[NIT].z1;
            prod_reg <= PW'(mag_reg) * PW'(sdlc_pkg::LOG_K);
            negp_reg <= neg_reg;
            z0p_reg  <= z0d_reg;
            z1p_reg  <= z1d_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 24: round half up, apply sign, add reference and clamp.
    // ------------------------------------------------------------------
    logic [PW:0]        rnd;
    logic [DMW-1:0]     dm;
    logic signed [SW-1:0] raw;
    sdlc_pkg::out_beat_t res;

    assign rnd = {1'b0, prod_reg} + ((PW + 1)'(1) << 31);
    assign dm  = rnd[PW:32];
    assign raw = negp_reg ? $signed(SW'(ref_level_reg)) - $signed(SW'(dm))
                          : $signed(SW'(ref_level_reg)) + $signed(SW'(dm));

    always_comb begin
        priority if (z0p_reg) begin
            res.level   = '0;
            res.clamped = 1'b1;
        end else if (z1p_reg) begin
            res.level   = sdlc_pkg::MAX_LEVEL;
            res.clamped = 1'b1;
        end else if (raw < 0) begin
            res.level   = '0;
            res.clamped = 1'b1;
        end else if (raw > $signed(SW'(sdlc_pkg::MAX_LEVEL))) begin
            res.level   = sdlc_pkg::MAX_LEVEL;
            res.clamped = 1'b1;
        end else begin
            res.level   = raw[sdlc_pkg::LEVEL_BITS-1:0];
            res.clamped = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= res;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.level <= sdlc_pkg::MAX_LEVEL)
        else $error("level above the upper clamp");

    a_inner_not_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.level != '0
         && m_data_reg.level != sdlc_pkg::MAX_LEVEL) |-> !m_data_reg.clamped)
        else $error("clamp flag on a level inside the range");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg) && m_valid_reg)
        else $error("pipeline moved during a stall");

    a_mantissa_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[4] && !side_reg[0].z0) |-> m0_reg[0][MB-1])
        else $error("mantissa not normalized");

endmodule

`default_nettype wire

[dv/sdlc_checker.sv]
// ----------------------------------------------------------------------------
// Speaker level checker
// Watches the input and result channels of the level compensation core,
// computes the expected level of every accepted input beat from its own copy
// of the registers, and compares each result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sdlc_checker (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    input  wire                 s_ready,
    input  sdlc_pkg::in_beat_t  s_data,
    input  wire                 m_valid,
    input  wire                 m_ready,
    input  sdlc_pkg::out_beat_t m_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [4:0]          paddr,
    input  wire  [31:0]         pwdata,
    input  wire                 pready,
    output int                  fail_count,
    output int                  pending_levels,
    output int                  levels_checked
);

    // Shadow copy of the configuration registers.
    logic signed [sdlc_pkg::COORD_BITS-1:0] spk_x, spk_y, spk_z, cen_x, cen_y, cen_z;
    logic [sdlc_pkg::LEVEL_BITS-1:0]        ref_lvl;

    sdlc_pkg::out_beat_t level_queue[$];

    // Fixed-point log2 in Q.16 of a positive value.
    function automatic longint log2_fix(longint unsigned v);
        int n;
        longint unsigned m;
        longint frac;
        n = 0;
        frac = 0;
        while (n < 63 && (v >> (n + 1)) != 0) n++;
        if (n >= 30) m = v >> (n - 30);
        else m = v << (30 - n);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(n) * 65536 + frac;
    endfunction

    function automatic longint unsigned sq_dist(
        logic signed [sdlc_pkg::COORD_BITS-1:0] a,
        logic signed [sdlc_pkg::COORD_BITS-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return longint'(d * d);
    endfunction

    // Expected level beat for one listener position.
    function automatic sdlc_pkg::out_beat_t speaker_level(sdlc_pkg::in_beat_t p);
        longint unsigned d0, dc, mag, dm;
        longint diff, lvl, maxl;
        sdlc_pkg::out_beat_t r;
        maxl = longint'(sdlc_pkg::MAX_LEVEL_DB) * 256;
        d0 = sq_dist(p.listener_x, spk_x) + sq_dist(p.listener_y, spk_y)
           + sq_dist(p.listener_z, spk_z);
        dc = sq_dist(spk_x, cen_x) + sq_dist(spk_y, cen_y) + sq_dist(spk_z, cen_z);
        r.clamped = 1'b0;
        if (d0 == 0) begin
            lvl = 0;
            r.clamped = 1'b1;
        end else if (dc == 0) begin
            lvl = maxl;
            r.clamped = 1'b1;
        end else begin
            diff = log2_fix(d0) - log2_fix(dc);
            mag = (diff < 0) ? -diff : diff;
            dm = (mag * 64'(sdlc_pkg::LOG_K) + (64'd1 << 31)) >> 32;
            lvl = (diff < 0) ? longint'(ref_lvl) - longint'(dm)
                             : longint'(ref_lvl) + longint'(dm);
            if (lvl > maxl) begin
                lvl = maxl;
                r.clamped = 1'b1;
            end
            if (lvl < 0) begin
                lvl = 0;
                r.clamped = 1'b1;
            end
        end
        r.level = lvl[sdlc_pkg::LEVEL_BITS-1:0];
        return r;
    endfunction

    assign pending_levels = level_queue.size();

    // Track register writes, predict accepted beats and check results.
    always @(posedge aclk) begin
        sdlc_pkg::out_beat_t exp_beat;
        int errs;
        errs = 0;
        if (!aresetn) begin
            spk_x <= '0; spk_y <= '0; spk_z <= '0;
            cen_x <= '0; cen_y <= '0; cen_z <= '0;
            ref_lvl <= sdlc_pkg::REF_LEVEL_RESET;
            level_queue.delete();
            fail_count <= 0;
            levels_checked <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[4:2])
                    sdlc_pkg::REG_SPEAKER_X: spk_x <= pwdata[15:0];
                    sdlc_pkg::REG_SPEAKER_Y: spk_y <= pwdata[15:0];
                    sdlc_pkg::REG_SPEAKER_Z: spk_z <= pwdata[15:0];
                    sdlc_pkg::REG_CENTER_X:  cen_x <= pwdata[15:0];
                    sdlc_pkg::REG_CENTER_Y:  cen_y <= pwdata[15:0];
                    sdlc_pkg::REG_CENTER_Z:  cen_z <= pwdata[15:0];
                    sdlc_pkg::REG_REF_LEVEL: ref_lvl <= pwdata[14:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) level_queue.push_back(speaker_level(s_data));
            if (m_valid && m_ready) begin
                levels_checked <= levels_checked + 1;
                if (level_queue.size() == 0) begin
                    $error("result beat with no expected level: level %0d clamped %0d",
                           m_data.level, m_data.clamped);
                    errs++;
                end else begin
                    exp_beat = level_queue.pop_front();
                    if (exp_beat.level !== m_data.level) begin
                        $error("level mismatch: expected %0d actual %0d",
                               exp_beat.level, m_data.level);
                        errs++;
                    end
                    if (exp_beat.clamped !== m_data.clamped) begin
                        $error("clamped mismatch: expected %0d actual %0d",
                               exp_beat.clamped, m_data.clamped);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

`default_nettype wire

[dv/speaker_distance_level_comp_core_test.sv]
// ----------------------------------------------------------------------------
// Speaker level compensation core test
// Drives listener positions in bursts under several speaker and centroid
// settings, stalls the result side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module speaker_distance_level_comp_core_test;

    localparam int LATENCY     = 24;
    localparam int CYCLE_LIMIT = 400000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    sdlc_pkg::in_beat_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    sdlc_pkg::out_beat_t m_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [4:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    int                  fail_count, pending_levels, levels_checked;
    int                  cycle_count = 0;
    int                  settings_run = 0;

    speaker_distance_level_comp_core DUT (.*);
    sdlc_checker checker_i (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("speaker_distance_level_comp_core verification failed");
            $finish;
        end
    end

    // Receiver ready is drawn at random on every clock, mostly high.
    always @(posedge aclk) begin
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 2) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic reg_write(sdlc_pkg::reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Wait until every result is back, then let the pipeline drain.
    task automatic drain();
        @(posedge aclk);
        while (pending_levels != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic send_pos(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        s_valid <= 1'b1;
        s_data <= {x, y, z};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic setup(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                         logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                         logic [14:0] rl);
        reg_write(sdlc_pkg::REG_SPEAKER_X, ({$urandom} & 32'hFFFF0000) | 32'(sx));
        reg_write(sdlc_pkg::REG_SPEAKER_Y, 32'(sy));
        reg_write(sdlc_pkg::REG_SPEAKER_Z, 32'(sz));
        reg_write(sdlc_pkg::REG_CENTER_X, 32'(cx));
        reg_write(sdlc_pkg::REG_CENTER_Y, 32'(cy));
        reg_write(sdlc_pkg::REG_CENTER_Z, 32'(cz));
        reg_write(sdlc_pkg::REG_REF_LEVEL, 32'(rl));
        settings_run++;
    endtask

    // Random burst of positions; near-speaker hits mixed in.
    task automatic random_phase(int count, logic [15:0] sx, logic [15:0] sy,
                                logic [15:0] sz);
        int sent, burst, gap;
        bit paused;
        logic [15:0] x, y, z;
        sent = 0;
        paused = 1'b0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++) begin
                case ($urandom_range(0, 9))
                    0: begin x = sx; y = sy; z = sz; end
                    1: begin
                        x = 16'(sx + $urandom_range(0, 6) - 3);
                        y = 16'(sy + $urandom_range(0, 6) - 3);
                        z = sz;
                    end
                    2: begin x = 16'h8000; y = 16'h7FFF; z = 16'($urandom); end
                    default: begin
                        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
                    end
                endcase
                send_pos(x, y, z);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap != 0 || sent >= count || (!paused && sent >= count / 2)) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // Hold the sender until every expected result has come.
            if (!paused && sent >= count / 2 && sent < count) begin
                paused = 1'b1;
                @(posedge aclk);
                while (pending_levels != 0) @(posedge aclk);
            end
        end
    endtask

    initial begin
        logic [15:0] sx, sy, sz;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset config (speaker on centroid), then extremes.
        send_pos(16'h0000, 16'h0000, 16'h0000);
        send_pos(16'h0001, 16'h0000, 16'h0000);
        s_valid <= 1'b0;
        drain();
        setup(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF);
        send_pos(16'h8000, 16'h8000, 16'h8000);
        send_pos(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_pos(16'h8001, 16'h8000, 16'h8000);
        send_pos(16'hFFFF, 16'h0000, 16'h5555);
        s_valid <= 1'b0;
        drain();
        setup(16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0);
        send_pos(16'd50, 16'd0, 16'd0);
        send_pos(16'd200, 16'd0, 16'd0);
        send_pos(16'd0, 16'd0, 16'd0);
        send_pos(16'd101, 16'd0, 16'd0);
        send_pos(16'h8000, 16'h8000, 16'h8000);
        s_valid <= 1'b0;
        drain();
        setup(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd19968);
        send_pos(16'd3, 16'd0, 16'd0);
        send_pos(16'd1, 16'd0, 16'd0);
        send_pos(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_pos(16'd2, 16'd0, 16'd0);
        s_valid <= 1'b0;
        drain();

        // Random phases with varied settings.
        for (int ph = 0; ph < 8; ph++) begin
            sx = 16'($urandom); sy = 16'($urandom); sz = 16'($urandom);
            if (ph == 0) setup(16'h7FFF, 16'h8000, 16'h0, 16'h8000, 16'h7FFF, 16'h0,
                               15'd30720);
            else if (ph == 1) setup(sx, sy, sz, 16'(sx + 16'd1), sy, sz, 15'd0);
            else setup(sx, sy, sz, 16'($urandom), 16'($urandom), 16'($urandom),
                       15'($urandom));
            if (ph == 0) begin sx = 16'h7FFF; sy = 16'h8000; sz = 16'h0; end
            random_phase(50, sx, sy, sz);
            drain();
        end

        $display("Ran %0d register settings; %0d level beats checked.",
                 settings_run, levels_checked);
        if (fail_count == 0) begin
            $display("speaker_distance_level_comp_core verification clean");
        end else begin
            $display("speaker_distance_level_comp_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[speaker_distance_level_comp_core.f]
hw/rtl/sdlc_pkg.sv
hw/rtl/speaker_distance_level_comp_core.sv
dv/sdlc_checker.sv
dv/speaker_distance_level_comp_core_test.sv
